// File: rtl/core/atuv_pkg.sv
// ----------------------------------------------------------------------------
// atuv_pkg
// Shared types and constants for the angle-to-unit-vector core.
// ----------------------------------------------------------------------------
package atuv_pkg;

  // Widths fixed by the stream fields
  localparam int GRID_W   = 16;
  localparam int SCALE_W  = 12;
  localparam int Q15_W    = 16;
  localparam int PHASE_W  = 23;   // fractional turn bits of the Q5.23 product
  localparam int ROT_W    = 32;   // x, y with 30 fraction bits; z in 2^-32 turn

  localparam logic [SCALE_W-1:0] TURNS_SCALE_RST = 12'd640;   // 2.5 turns
  localparam int ATAN_LEN = 24;

  // CORDIC gain, Q2.30
  localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 32'sd652032874;

  // atan(2^-i) in units of 2^-32 turn, rounded to nearest
  localparam logic [ROT_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Rotation pipeline word
  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
    logic                    neg;   // phase was folded by half a turn
    logic                    last;
  } rot_t;

endpackage

// File: rtl/core/atuv_phase.sv
// ----------------------------------------------------------------------------
// atuv_phase
// Scale multiply, wrap to one turn, truncate and quadrant fold (two stages).
// ----------------------------------------------------------------------------
module atuv_phase
  import atuv_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [SCALE_W-1:0]        turns_scale,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [GRID_W-1:0]  grid_value,
  input  logic                      last_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rot_t                      out_data
);

  localparam int DROP_BITS = ROT_W - SAMPLE_BITS;
  localparam logic [ROT_W-1:0] KEEP_MASK = ~((32'd1 << DROP_BITS) - 32'd1);
  localparam int PROD_W = GRID_W + SCALE_W + 1;

  // stage A: product
  logic                 a_valid_r;
  logic [PHASE_W-1:0]   a_phase_r;
  logic                 a_last_r;
  logic                 a_en;
  logic signed [PROD_W-1:0] prod;

  // stage B: folded phase, CORDIC start vector
  logic                 b_valid_r;
  rot_t                 b_data_r;
  rot_t                 b_data_nxt;
  logic                 b_en;
  logic [ROT_W-1:0]     t32;
  logic                 fold;

  assign b_en     = !b_valid_r || out_ready;
  assign a_en     = !a_valid_r || b_en;
  assign in_ready = a_en;

  assign prod = grid_value * $signed({1'b0, turns_scale});

  always_comb begin
    t32  = {a_phase_r, {(ROT_W-PHASE_W){1'b0}}} & KEEP_MASK;
    // beyond +-1/4 turn: flipping the sign bit moves it by half a turn.
    // Exactly +1/4 stays, everything in [-1/2, -1/4) folds.
    fold = (t32[ROT_W-1] != t32[ROT_W-2]) &&
           (t32[ROT_W-1] || (t32[ROT_W-3:0] != '0));
    b_data_nxt.x    = CORDIC_GAIN;
    b_data_nxt.y    = '0;
    b_data_nxt.z    = $signed({t32[ROT_W-1] ^ fold, t32[ROT_W-2:0]});
    b_data_nxt.neg  = fold;
    b_data_nxt.last = a_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_en) a_valid_r <= in_valid;
      if (b_en) b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en && in_valid) begin
      a_phase_r <= prod[PHASE_W-1:0];
      a_last_r  <= last_in;
    end
    if (b_en && a_valid_r) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_data  = b_data_r;

endmodule

// File: rtl/core/atuv_rot_stage.sv
// ----------------------------------------------------------------------------
// atuv_rot_stage
// One registered CORDIC micro-rotation by atan(2^-STAGE).
// ----------------------------------------------------------------------------
module atuv_rot_stage
  import atuv_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  rot_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rot_t out_data
);

  localparam logic signed [ROT_W-1:0] ANGLE = $signed(ATAN_TABLE[STAGE]);

  logic valid_r;
  rot_t data_r;
  rot_t data_nxt;
  logic en;
  logic signed [ROT_W-1:0] xs;
  logic signed [ROT_W-1:0] ys;

  assign en       = !valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    xs       = in_data.x >>> STAGE;
    ys       = in_data.y >>> STAGE;
    data_nxt = in_data;
    if (!in_data.z[ROT_W-1]) begin
      data_nxt.x = in_data.x - ys;
      data_nxt.y = in_data.y + xs;
      data_nxt.z = in_data.z - ANGLE;
    end else begin
      data_nxt.x = in_data.x + ys;
      data_nxt.y = in_data.y - xs;
      data_nxt.z = in_data.z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: rtl/core/atuv_round.sv
// ----------------------------------------------------------------------------
// atuv_round
// Round to Q1.15, saturate, undo the fold; output register.
// ----------------------------------------------------------------------------
module atuv_round
  import atuv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rot_t             in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [Q15_W-1:0] force_x,
  output logic [Q15_W-1:0] force_y,
  output logic             last_out
);

  localparam int SUM_W = ROT_W + 1;
  localparam int RND_W = SUM_W - 15;
  localparam logic signed [RND_W-1:0] SAT_HI = 18'sd32767;
  localparam logic signed [RND_W-1:0] SAT_LO = -18'sd32767;

  logic             valid_r;
  logic [Q15_W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic             last_r;
  logic             en;

  function automatic logic [Q15_W-1:0] to_q15(logic signed [ROT_W-1:0] v, logic neg);
    logic signed [SUM_W-1:0] sum;
    logic signed [RND_W-1:0] r;
    sum = $signed({v[ROT_W-1], v}) + $signed(SUM_W'(16384));
    r   = RND_W'(sum >>> 15);
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    if (neg) r = -r;
    return r[Q15_W-1:0];
  endfunction

  assign en       = !valid_r || out_ready;
  assign in_ready = en;

  assign x_nxt = to_q15(in_data.x, in_data.neg);
  assign y_nxt = to_q15(in_data.y, in_data.neg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      last_r <= in_data.last;
    end
  end

  assign out_valid = valid_r;
  assign force_x   = x_r;
  assign force_y   = y_r;
  assign last_out  = last_r;

endmodule

// File: rtl/core/angle_to_unit_vector_core.sv
// ----------------------------------------------------------------------------
// angle_to_unit_vector_core
// Scaled, wrapped phase to unit vector (cos, sin) via pipelined CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one grid value per transfer (signed Q1.15 in in_tdata), end of
//           grid on in_tlast.
//   out_* : cos in out_tdata[15:0], sin in out_tdata[31:16], both signed
//           Q1.15; out_tlast is the matching in_tlast.
//   cfg_* : writes turns_scale (unsigned Q4.8 turns per unit input). Always
//           ready; write only while the pipeline is empty.
// Register path from input transfer to out_tvalid: multiply, fold,
//   one register per CORDIC micro-rotation, rounding.
// Throughput: one transfer per cycle while out_tready stays high, set by the
//   fully pipelined rotation chain; every stage holds one item.
// Reset (rst_n low, synchronous): all stage valid bits clear, turns_scale
//   returns to 2.5 turns.
// Stall: each stage advances when it is empty or its successor advances,
//   so bubbles collapse and input keeps being taken while a result waits
//   on out_tready, until every stage is full.
// ----------------------------------------------------------------------------
module angle_to_unit_vector_core
  import atuv_pkg::*;
#(
  parameter int ROTATION_STAGES = 16,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [GRID_W-1:0]   in_tdata,    // [15:0] grid_value
  input  logic                in_tlast,    // last_in
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [2*Q15_W-1:0]  out_tdata,   // [15:0] force_x, [31:16] force_y
  output logic                out_tlast,   // last_out
  // configuration write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SCALE_W-1:0]  cfg_data     // turns_scale
);

  logic [SCALE_W-1:0] turns_scale_r;
  logic [SCALE_W-1:0] turns_scale_nxt;

  // rotation chain: index 0 is the fold output, ROTATION_STAGES the last
  rot_t rot_d   [ROTATION_STAGES+1];
  logic rot_v   [ROTATION_STAGES+1];
  logic rot_rdy [ROTATION_STAGES+1];

  logic [Q15_W-1:0] force_x;
  logic [Q15_W-1:0] force_y;

  assign cfg_ready       = 1'b1;
  assign turns_scale_nxt = (cfg_valid && cfg_ready) ? cfg_data : turns_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turns_scale_r <= TURNS_SCALE_RST;
    end else begin
      turns_scale_r <= turns_scale_nxt;
    end
  end

  atuv_phase #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .turns_scale (turns_scale_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .grid_value  ($signed(in_tdata)),
    .last_in     (in_tlast),
    .out_valid   (rot_v[0]),
    .out_ready   (rot_rdy[0]),
    .out_data    (rot_d[0])
  );

  for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_rot
    atuv_rot_stage #(
      .STAGE (i)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (rot_v[i]),
      .in_ready  (rot_rdy[i]),
      .in_data   (rot_d[i]),
      .out_valid (rot_v[i+1]),
      .out_ready (rot_rdy[i+1]),
      .out_data  (rot_d[i+1])
    );
  end

  atuv_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rot_v[ROTATION_STAGES]),
    .in_ready  (rot_rdy[ROTATION_STAGES]),
    .in_data   (rot_d[ROTATION_STAGES]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .force_x   (force_x),
    .force_y   (force_y),
    .last_out  (out_tlast)
  );

  assign out_tdata = {force_y, force_x};

endmodule

// File: rtl/core/atuv_checker.sv
// ----------------------------------------------------------------------------
// atuv_checker
// Port-level checks for angle_to_unit_vector_core, bound to the top level.
// ----------------------------------------------------------------------------
module atuv_checker
  import atuv_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [2*Q15_W-1:0]  out_tdata,
  input logic                out_tlast,
  input logic                cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // nothing leaves the pipeline right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a free-running sink never backs up the input
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled with sink ready");

  // saturation keeps both components off the most negative code
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] != 16'h8000) && (out_tdata[31:16] != 16'h8000))
    else $error("result outside +-32767");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind angle_to_unit_vector_core atuv_checker u_atuv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_ready  (cfg_ready)
);

// File: sim/angle_to_unit_vector_core_tb.sv
// ----------------------------------------------------------------------------
// angle_to_unit_vector_core_tb
// Self-checking bench for the phase-to-unit-vector core.
// Grid values stream in. Every input transfer is turned into a predicted
// (cos, sin, last) triple by a bit-exact CORDIC predictor. Each output
// transfer is checked against the oldest prediction. The run covers directed
// corners (grid extremes, quadrant fold edges, scale extremes, phase
// truncation), a long back-pressure hold and random grids under four
// idle/stall mixes.
// ----------------------------------------------------------------------------
module angle_to_unit_vector_core_tb;
  import atuv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES      = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int LATENCY     = STAGES + 3;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 150;       // long receiver hold-off

  localparam longint QUARTER_TURN = 64'sd1 << 30;   // in 2^-32 turn units
  localparam longint HALF_TURN    = 64'sd1 << 31;
  localparam longint Q15_LIM      = 64'sd32767;

  // One result item as it leaves the core
  typedef struct packed {
    logic signed [Q15_W-1:0] fx;     // cos
    logic signed [Q15_W-1:0] fy;     // sin
    logic                    last;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [GRID_W-1:0]  in_tdata = '0;      // [15:0] grid_value
  logic               in_tlast = 1'b0;    // last_in
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [2*Q15_W-1:0] out_tdata;          // [15:0] force_x, [31:16] force_y
  logic               out_tlast;          // last_out
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [SCALE_W-1:0] cfg_data = '0;      // turns_scale

  // Predictor state: the register copy and the results still in flight
  logic [SCALE_W-1:0] turns_scale_model = TURNS_SCALE_RST;
  vec_t               pending_vectors[$];

  int mismatches = 0;
  int cycles     = 0;

  // Idle knobs, percent of cycles
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  // Hold-off request: the test bumps hold_req, the receiver process counts
  int hold_req  = 0;
  int hold_ack  = 0;
  int hold_left = 0;

  angle_to_unit_vector_core #(
    .ROTATION_STAGES (STAGES),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Round Q2.30 to Q1.15 (half up, floor shift), clamp symmetric, undo fold
  function automatic logic signed [Q15_W-1:0] round_q15(input longint v, input logic flip);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > Q15_LIM) r = Q15_LIM;
    if (r < -Q15_LIM) r = -Q15_LIM;
    if (flip) r = -r;
    return r[Q15_W-1:0];
  endfunction

  function automatic vec_t unit_vector_of(input logic signed [GRID_W-1:0] grid,
                                          input logic [SCALE_W-1:0] scale,
                                          input logic last);
    longint      prod, z, x, y, xs, ys;
    logic [31:0] phase;
    logic        flip;
    vec_t        v;
    // Q1.15 * Q4.8 = Q5.23 turns; keep only the fractional turn
    prod  = longint'(grid) * longint'(scale);
    phase = {prod[PHASE_W-1:0], 9'b0};
    phase &= ~((32'd1 << (32 - SAMPLE_BITS)) - 32'd1);
    z     = longint'($signed(phase));
    // fold into +-1/4 turn, negate both outputs later
    flip = 1'b0;
    if (z > QUARTER_TURN || z < -QUARTER_TURN) begin
      flip = 1'b1;
      z    = (z >= 0) ? z - HALF_TURN : z + HALF_TURN;
    end
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TABLE[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TABLE[i]);
      end
    end
    v.fx   = round_q15(x, flip);
    v.fy   = round_q15(y, flip);
    v.last = last;
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("[%0d] MISMATCH %s: expected %0d, got %0d", cycles, what, want, got);
    mismatches++;
  endtask

  // Receiver: random stall per cycle, or a counted hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Checker: every output transfer against the oldest prediction
  always @(posedge clk) begin
    vec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_vectors.size() == 0) begin
        report_mismatch("result with nothing pending (tdata)", 0, out_tdata);
      end else begin
        want = pending_vectors.pop_front();
        if ($signed(out_tdata[15:0]) !== want.fx)
          report_mismatch("force_x", want.fx, $signed(out_tdata[15:0]));
        if ($signed(out_tdata[31:16]) !== want.fy)
          report_mismatch("force_y", want.fy, $signed(out_tdata[31:16]));
        if (out_tlast !== want.last)
          report_mismatch("last_out", want.last, out_tlast);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one grid value; in_tvalid stays high after the transfer so that
  // back-to-back items never see a low/high pair in the same step.
  task automatic send_grid(input logic [GRID_W-1:0] grid, input logic last);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= GRID_W'($urandom);   // junk while idle
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= grid;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    pending_vectors.push_back(unit_vector_of(grid, turns_scale_model, last));
  endtask

  // Stop offering and wait until every predicted result has come out
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_vectors.size() != 0);
  endtask

  // Register write, only with the pipeline empty
  task automatic write_turns_scale(input logic [SCALE_W-1:0] scale);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_data  <= scale;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    turns_scale_model = scale;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Default 2.5 turns straight out of reset, grid extremes, both last values
  task automatic test_reset_scale();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_grid(16'h8000, 1'b0);   // most negative
    send_grid(16'h7FFF, 1'b0);   // most positive
    send_grid(16'h0000, 1'b1);
    send_grid(16'hFFFF, 1'b0);
    send_grid(16'h0001, 1'b1);
    send_grid(16'h4000, 1'b0);
  endtask

  // At 1 turn per unit, grid 8192 is a quarter turn: hit both sides of the
  // fold edge, the half turn and three quarters
  task automatic test_quadrant_fold();
    write_turns_scale(12'd256);
    send_grid(16'd8192, 1'b0);   // exactly +1/4, not folded
    send_grid(16'd8193, 1'b0);   // just past, folded
    send_grid(16'd8191, 1'b0);
    send_grid(-16'sd8192, 1'b0); // exactly -1/4
    send_grid(-16'sd8193, 1'b0);
    send_grid(16'd16384, 1'b1);  // half turn, reads as -1/2
    send_grid(16'd16383, 1'b0);
    send_grid(-16'sd16384, 1'b0);
    send_grid(16'd24576, 1'b0);  // 3/4 turn wraps to -1/4
    send_grid(16'd24577, 1'b1);
  endtask

  // Zero scale, full scale, and the smallest scale where phase truncation
  // throws small products away
  task automatic test_scale_extremes();
    write_turns_scale(12'd0);
    send_grid(16'h8000, 1'b0);
    send_grid(16'h7FFF, 1'b1);
    write_turns_scale(12'd4095);
    send_grid(16'h8000, 1'b0);
    send_grid(16'h7FFF, 1'b0);
    send_grid(16'hFFFF, 1'b0);
    send_grid(16'h5555, 1'b1);
    write_turns_scale(12'd1);
    send_grid(16'd127, 1'b0);    // below the kept phase bits
    send_grid(16'd128, 1'b0);    // first kept phase bit
    send_grid(16'h8000, 1'b1);
  endtask

  // Receiver holds off long while the sender keeps going; the pipeline
  // fills and in_tready must drop without losing a transfer
  task automatic test_backpressure();
    write_turns_scale(TURNS_SCALE_RST);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req++;
    for (int n = 0; n < 80; n++)
      send_grid(GRID_W'($urandom), (n % 20) == 19);
  endtask

  // Random grids of random length, last on the final element of each
  task automatic test_random_grid(input int count, input int tx_pct, input int rx_pct,
                                  input logic [SCALE_W-1:0] scale);
    int run_left;
    logic [GRID_W-1:0] grid;
    write_turns_scale(scale);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    run_left     = $urandom_range(32, 1);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(15))
        0:       grid = 16'h8000;
        1:       grid = 16'h7FFF;
        2:       grid = GRID_W'($urandom_range(255));
        default: grid = GRID_W'($urandom);
      endcase
      run_left--;
      send_grid(grid, run_left == 0);
      if (run_left == 0) run_left = $urandom_range(32, 1);
    end
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_scale();
    test_quadrant_fold();
    test_scale_extremes();
    test_backpressure();

    // four idle mixes, each under its own scale
    test_random_grid(500, 0, 0, SCALE_W'($urandom_range(4095)));
    test_random_grid(500, 74, 0, 12'd4095);
    test_random_grid(500, 0, 74, SCALE_W'($urandom_range(16, 1)));
    test_random_grid(500, 38, 38, TURNS_SCALE_RST);

    // let the tail flush, then make sure nothing extra shows up
    drain_pipeline();
    repeat (LATENCY + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
